[design/tanh_neuron_batch_trainer_top_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the tanh neuron batch trainer
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef TANH_NEURON_BATCH_TRAINER_TOP_DEFINES_SVH
`define TANH_NEURON_BATCH_TRAINER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TNBT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TNBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/tnbt_pkg.sv]
// ---------------------------------------------------------------------------
// tnbt_pkg
// Types, codes and the tanh node table shared by the neuron trainer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tnbt_pkg;

   localparam logic [1:0] ACT_EVAL   = 2'd0;
   localparam logic [1:0] ACT_TRAIN  = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;

   localparam int CELLS_W  = 18;
   localparam int VALUE_W  = 16;
   localparam int WEIGHT_W = 32;
   localparam int GRAD_W   = 48;
   localparam int SCALE_W  = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_TANH_A,
      ST_TANH_B,
      ST_GRAD_A,
      ST_GRAD_B,
      ST_ACC,
      ST_UPD_A,
      ST_UPD_B,
      ST_UPD_C,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_req;
      logic clr_idx;
      logic inc_idx;
      logic sum_en;
      logic tanh_a;
      logic tanh_b;
      logic grad_a;
      logic grad_b;
      logic acc_en;
      logic upd_a;
      logic upd_b;
      logic upd_c;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic       last_idx;
      logic [1:0] action;
      logic       out_free;
   } status_type;

   typedef logic [14:0] half_table_type [0:128];

   function automatic half_table_type build_half_table();
      half_table_type t;
      logic [63:0]    e;
      logic [63:0]    den;
      logic [63:0]    rem;
      logic [63:0]    q;
      e = 64'd1 << 32;
      for (int m = 0; m < 129; m++) begin
         if (m > 0) begin
            e = (e * 64'd3790295335 + (64'd1 << 31)) >> 32;
         end
         den = (64'd1 << 32) + e;
         rem = (((64'd1 << 32) - e) << 15) + (den >> 1);
         q   = 64'd0;
         for (int b = 17; b >= 0; b--) begin
            if (rem >= (den << b)) begin
               rem  = rem - (den << b);
               q[b] = 1'b1;
            end
         end
         t[m] = (q > 64'd32767) ? 15'h7fff : q[14:0];
      end
      return t;
   endfunction

   localparam half_table_type TANH_HALF = build_half_table();

   function automatic logic signed [15:0] tanh_node(input logic [8:0] k);
      logic [8:0]         j;
      logic signed [15:0] v;
      j = (k >= 9'd128) ? (k - 9'd128) : (9'd128 - k);
      v = signed'({1'b0, TANH_HALF[j[7:0]]});
      return (k >= 9'd128) ? v : -v;
   endfunction

endpackage

[design/tanh_neuron_batch_trainer_top.sv]
// ---------------------------------------------------------------------------
// tanh_neuron_batch_trainer_top
// Single tanh neuron with batch gradient accumulation and weight update.
// ---------------------------------------------------------------------------
// A request on the req_ channel carries an action, nine 2-bit cells, the side
// to move and the expected result; each request yields one response on the
// rsp_ channel carrying the Q1.15 value (zero for an update request).
// Requests are taken one at a time: req_stall is low only while idle.
// An evaluate request runs the sum and tanh steps, a training request adds the
// gradient and accumulate steps, and an update request runs the weight update
// loop; the sum and accumulate loops visit one weight a cycle, and each weight
// update passes through a three-step multiply. The response sits in an output
// register, so a stalled receiver only holds the block once a second result
// is ready to be written there. The step scale is to be written through
// csr_wr_en and csr_wr_data only while idle; the block does not enforce this.
// Synchronous reset clears the weights and accumulators, restores the step
// scale and leaves the response channel empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tanh_neuron_batch_trainer_top #(
   parameter int CELLS = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic [tnbt_pkg::CELLS_W-1:0]        req_cells,
   input  logic                                req_side_to_move,
   input  logic signed [1:0]                   req_expected,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [tnbt_pkg::VALUE_W-1:0] rsp_value,
   input  logic                                csr_wr_en,
   input  logic [tnbt_pkg::SCALE_W-1:0]        csr_wr_data
);
   import tnbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   tnbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tnbt_datapath #(
      .CELLS (CELLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_action       (req_action),
      .req_cells        (req_cells),
      .req_side_to_move (req_side_to_move),
      .req_expected     (req_expected),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_value        (rsp_value)
   );

endmodule

[design/tnbt_ctrl.sv]
// ---------------------------------------------------------------------------
// tnbt_ctrl
// Sequencer that steps the datapath through sum, tanh, gradient and update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnbt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tnbt_pkg::status_type status,
   output tnbt_pkg::cmd_type    cmd
);
   import tnbt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_idx  = 1'b1;
               state_in     = ST_SUM;
            end
         end
         ST_SUM: begin
            if (status.action == ACT_UPDATE) begin
               state_in = ST_UPD_A;
            end else begin
               cmd.sum_en = 1'b1;
               if (status.last_idx) begin
                  state_in = ST_TANH_A;
               end else begin
                  cmd.inc_idx = 1'b1;
               end
            end
         end
         ST_TANH_A: begin
            cmd.tanh_a = 1'b1;
            state_in   = ST_TANH_B;
         end
         ST_TANH_B: begin
            cmd.tanh_b = 1'b1;
            state_in   = (status.action == ACT_TRAIN) ? ST_GRAD_A : ST_DONE;
         end
         ST_GRAD_A: begin
            cmd.grad_a = 1'b1;
            state_in   = ST_GRAD_B;
         end
         ST_GRAD_B: begin
            cmd.grad_b  = 1'b1;
            cmd.clr_idx = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            if (status.last_idx) begin
               state_in = ST_DONE;
            end else begin
               cmd.inc_idx = 1'b1;
            end
         end
         ST_UPD_A: begin
            cmd.upd_a = 1'b1;
            state_in  = ST_UPD_B;
         end
         ST_UPD_B: begin
            cmd.upd_b = 1'b1;
            state_in  = ST_UPD_C;
         end
         ST_UPD_C: begin
            cmd.upd_c = 1'b1;
            if (status.last_idx) begin
               state_in = ST_DONE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_UPD_A;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/tnbt_datapath.sv]
// ---------------------------------------------------------------------------
// tnbt_datapath
// Weights, gradient accumulators, tanh interpolation and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnbt_datapath #(
   parameter int CELLS = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tnbt_pkg::cmd_type                   cmd,
   output tnbt_pkg::status_type                status,
   input  logic [1:0]                          req_action,
   input  logic [tnbt_pkg::CELLS_W-1:0]        req_cells,
   input  logic                                req_side_to_move,
   input  logic signed [1:0]                   req_expected,
   input  logic                                csr_wr_en,
   input  logic [tnbt_pkg::SCALE_W-1:0]        csr_wr_data,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [tnbt_pkg::VALUE_W-1:0] rsp_value
);
   import tnbt_pkg::*;

   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SUM_W = 33 + $clog2(CELLS);

   logic [1:0]                  action_ff;
   logic [CELLS_W-1:0]          cells_ff;
   logic                        side_ff;
   logic [1:0]                  expected_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic signed [SUM_W-1:0]     sum_ff;
   logic signed [15:0]          lo_ff;
   logic signed [30:0]          term_ff;
   logic                        sat_ff;
   logic signed [15:0]          satval_ff;
   logic signed [15:0]          y_ff;
   logic signed [31:0]          d_ff;
   logic signed [18:0]          e2_ff;
   logic signed [35:0]          g_ff;
   logic [47:0]                 a_ff;
   logic [63:0]                 p_ff;
   logic [64:0]                 hi_ff;
   logic signed [WEIGHT_W-1:0]  weights_ff [CELLS];
   logic signed [GRAD_W-1:0]    grads_ff [CELLS];
   logic [SCALE_W-1:0]          step_ff;
   logic                        rsp_valid_ff;
   logic signed [VALUE_W-1:0]   rsp_value_ff;

   logic [CELLS_W-1:0]          cells_sh;
   logic [1:0]                  code;
   logic                        x_nz;
   logic                        x_neg;
   logic signed [WEIGHT_W-1:0]  w_cur;
   logic signed [GRAD_W-1:0]    g_cur;
   logic signed [SUM_W-1:0]     w_ext;
   logic signed [SUM_W-1:0]     sum_in;
   logic [19:0]                 u;
   logic [8:0]                  k_lo;
   logic signed [15:0]          node_lo;
   logic signed [15:0]          node_hi;
   logic signed [30:0]          diff_ext;
   logic signed [30:0]          f_ext;
   logic signed [30:0]          term_in;
   logic                        sat_hi;
   logic                        sat_lo;
   logic signed [30:0]          term_rnd;
   logic signed [16:0]          y_sum;
   logic signed [15:0]          y_in;
   logic signed [31:0]          yy;
   logic signed [18:0]          exp_q;
   logic signed [18:0]          e2_in;
   logic signed [50:0]          de_prod;
   logic signed [50:0]          de_rnd;
   logic signed [48:0]          g_ext;
   logic signed [48:0]          acc_sum;
   logic signed [GRAD_W-1:0]    acc_in;
   logic [47:0]                 a_in;
   logic [64:0]                 hi_in;
   logic [64:0]                 hi_rnd;
   logic [35:0]                 mag;
   logic signed [37:0]          w_new;
   logic signed [WEIGHT_W-1:0]  w_sat;

   assign cells_sh = cells_ff >> {idx_ff, 1'b0};
   assign code     = cells_sh[1:0];
   assign x_nz     = (code == 2'd1) || (code == 2'd2);
   assign x_neg    = (code == 2'd2) ^ side_ff;
   assign w_cur    = weights_ff[idx_ff];
   assign g_cur    = grads_ff[idx_ff];
   assign w_ext    = SUM_W'(w_cur);

   always_comb begin
      sum_in = sum_ff;
      if (x_nz) begin
         sum_in = x_neg ? (sum_ff - w_ext) : (sum_ff + w_ext);
      end
   end

   assign u        = sum_ff[19:0] + 20'h80000;
   assign k_lo     = {1'b0, u[19:12]};
   assign node_lo  = tanh_node(k_lo);
   assign node_hi  = tanh_node(k_lo + 9'd1);
   assign diff_ext = 31'(node_hi) - 31'(node_lo);
   assign f_ext    = signed'({19'd0, u[11:0]});
   assign term_in  = diff_ext * f_ext;
   assign sat_hi   = sum_ff >= SUM_W'(524288);
   assign sat_lo   = sum_ff < -SUM_W'(524288);

   assign term_rnd = (term_ff + 31'sd2048) >>> 12;
   assign y_sum    = 17'(lo_ff) + term_rnd[16:0];
   assign y_in     = sat_ff ? satval_ff : y_sum[15:0];

   assign yy       = 32'(y_ff) * 32'(y_ff);

   always_comb begin
      case (expected_ff)
         2'd0:    exp_q = 19'sd0;
         2'd1:    exp_q = 19'sd32768;
         default: exp_q = -19'sd32768;
      endcase
   end

   assign e2_in   = (19'(y_ff) - exp_q) <<< 1;
   assign de_prod = 51'(d_ff) * 51'(e2_ff);
   assign de_rnd  = (de_prod + 51'sd16384) >>> 15;

   assign g_ext = 49'(g_ff);

   always_comb begin
      acc_sum = 49'(g_cur);
      if (x_nz) begin
         acc_sum = x_neg ? (49'(g_cur) - g_ext) : (49'(g_cur) + g_ext);
      end
      if (acc_sum > 49'sh0_7fff_ffff_ffff) begin
         acc_in = 48'sh7fff_ffff_ffff;
      end else if (acc_sum < -49'sh0_8000_0000_0000) begin
         acc_in = 48'sh8000_0000_0000;
      end else begin
         acc_in = acc_sum[47:0];
      end
   end

   assign a_in   = g_cur[GRAD_W-1] ? 48'(-g_cur) : 48'(g_cur);
   assign hi_in  = 65'(a_ff * 64'(step_ff[31:16])) + 65'(p_ff >> 16);
   assign hi_rnd = hi_ff + (65'd1 << 29);
   assign mag    = {1'b0, hi_rnd[64:30]};

   always_comb begin
      if (g_cur[GRAD_W-1]) begin
         w_new = 38'(w_cur) + signed'({2'b00, mag});
      end else begin
         w_new = 38'(w_cur) - signed'({2'b00, mag});
      end
      if (w_new > 38'sh0_7fff_ffff) begin
         w_sat = 32'sh7fff_ffff;
      end else if (w_new < -38'sh0_8000_0000) begin
         w_sat = 32'sh8000_0000;
      end else begin
         w_sat = w_new[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff   <= req_action;
         cells_ff    <= req_cells;
         side_ff     <= req_side_to_move;
         expected_ff <= req_expected;
         sum_ff      <= '0;
      end else if (cmd.sum_en) begin
         sum_ff <= sum_in;
      end
      if (cmd.clr_idx) begin
         idx_ff <= '0;
      end else if (cmd.inc_idx) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.tanh_a) begin
         lo_ff     <= node_lo;
         term_ff   <= term_in;
         sat_ff    <= sat_hi || sat_lo;
         satval_ff <= sat_hi ? 16'sd32767 : -16'sd32767;
      end
      if (cmd.tanh_b) begin
         y_ff <= y_in;
      end
      if (cmd.grad_a) begin
         d_ff  <= 32'sh4000_0000 - yy;
         e2_ff <= e2_in;
      end
      if (cmd.grad_b) begin
         g_ff <= de_rnd[35:0];
      end
      if (cmd.upd_a) begin
         a_ff <= a_in;
         p_ff <= a_in * 64'(step_ff[15:0]);
      end
      if (cmd.upd_b) begin
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            weights_ff[i] <= '0;
            grads_ff[i]   <= '0;
         end
         step_ff <= SCALE_W'(171799);
      end else begin
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         if (cmd.acc_en) begin
            grads_ff[idx_ff] <= acc_in;
         end
         if (cmd.upd_c) begin
            weights_ff[idx_ff] <= w_sat;
            grads_ff[idx_ff]   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_value_ff <= (action_ff == ACT_UPDATE) ? '0 : y_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign status.last_idx = (idx_ff == IDX_W'(CELLS - 1));
   assign status.action   = action_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

[design/tnbt_checker.sv]
// ---------------------------------------------------------------------------
// tnbt_checker
// Port-level checks on the request and response channels of the trainer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tanh_neuron_batch_trainer_top_defines.svh"

module tnbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_value
);

   `TNBT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value), "stalled response changed")
   `TNBT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request taken while still working on the last")
   `TNBT_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && !req_stall && !(rsp_valid && !rsp_stall), rsp_valid == $past(rsp_valid), "response appeared straight after a request")

endmodule

bind tanh_neuron_batch_trainer_top tnbt_checker u_tnbt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value)
);

[tb/testbench.sv]
// ---------------------------------------------------------------------------
// Testbench for the tanh neuron batch trainer
// Drives random bursts of evaluate, train and update requests under several
// step scales, predicts each value from its own copy of the weights and
// accumulators, and checks every response in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import tnbt_pkg::*;

   localparam logic [1:0] ACT_SPARE   = 2'd3;
   localparam logic [1:0] CELL_FIRST  = 2'd1;
   localparam logic [1:0] CELL_SECOND = 2'd2;
   localparam int         NCELL       = 9;
   localparam int         SETTLE      = 40;

   typedef struct {
      logic [1:0]         action;
      logic [CELLS_W-1:0] cells;
      logic               side;
      logic [1:0]         target;
   } request_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_action = '0;
   logic [CELLS_W-1:0]         req_cells = '0;
   logic                       req_side_to_move = 1'b0;
   logic signed [1:0]          req_expected = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_value;
   logic                       csr_wr_en = 1'b0;
   logic [SCALE_W-1:0]         csr_wr_data = '0;

   request_type               pending_reqs[$];
   logic signed [VALUE_W-1:0] value_queue[$];
   int                        mismatches = 0;
   logic                      took = 1'b0;
   int                        burst_left = 0;
   int                        gap_left = 0;
   int                        stall_mode = 0;
   int                        stall_span = 0;

   longint                    node[0:256];
   logic [31:0]               scale_m;
   longint                    weight_m[NCELL];
   longint                    grad_m[NCELL];

   tanh_neuron_batch_trainer_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_cells(req_cells), .req_side_to_move(req_side_to_move),
      .req_expected(req_expected),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic void build_nodes();
      longint unsigned e;
      longint unsigned den;
      longint unsigned q;
      e = 64'd1 << 32;
      for (int m = 0; m <= 128; m++) begin
         if (m > 0) begin
            e = (e * 64'd3790295335 + (64'd1 << 31)) >> 32;
         end
         den = (64'd1 << 32) + e;
         q = ((((64'd1 << 32) - e) << 15) + (den >> 1)) / den;
         if (q > 64'd32767) begin
            q = 64'd32767;
         end
         node[128 + m] = longint'(q);
         node[128 - m] = -longint'(q);
      end
   endfunction

   function automatic longint tanh_value(longint s);
      longint u;
      longint k;
      longint f;
      if (s >= (longint'(8) << 16)) begin
         return 32767;
      end
      if (s < -(longint'(8) << 16)) begin
         return -32767;
      end
      u = s + (longint'(8) << 16);
      k = u >>> 12;
      f = u & 4095;
      return node[k] + rnd_shift((node[k + 1] - node[k]) * f, 12);
   endfunction

   function automatic void apply_weight_step();
      longint unsigned mag;
      longint unsigned hi;
      longint          delta;
      longint          w;
      for (int i = 0; i < NCELL; i++) begin
         mag = (grad_m[i] < 0) ? longint'(-grad_m[i]) : longint'(grad_m[i]);
         hi = mag * longint'(scale_m[31:16])
              + ((mag * longint'(scale_m[15:0])) >> 16);
         delta = longint'((hi + (64'd1 << 29)) >> 30);
         if (grad_m[i] < 0) begin
            delta = -delta;
         end
         w = weight_m[i] - delta;
         if (w > 64'sd2147483647) begin
            w = 64'sd2147483647;
         end
         if (w < -64'sd2147483648) begin
            w = -64'sd2147483648;
         end
         weight_m[i] = w;
         grad_m[i] = 0;
      end
   endfunction

   function automatic logic signed [15:0] neuron_value(request_type r);
      longint x[NCELL];
      longint sum;
      longint team;
      longint target;
      longint y;
      longint g;
      longint acc;
      logic [1:0] code;
      if (r.action == ACT_UPDATE) begin
         apply_weight_step();
         return 16'sd0;
      end
      team = r.side ? -1 : 1;
      target = (r.target == 2'd0) ? 0 : ((r.target == 2'd1) ? 1 : -1);
      sum = 0;
      for (int i = 0; i < NCELL; i++) begin
         code = r.cells[2*i +: 2];
         x[i] = (code == CELL_FIRST) ? team : ((code == CELL_SECOND) ? -team : 0);
         sum += x[i] * weight_m[i];
      end
      y = tanh_value(sum);
      if (r.action == ACT_TRAIN) begin
         g = rnd_shift(((longint'(1) << 30) - y * y) * (2 * (y - target * 32768)), 15);
         for (int i = 0; i < NCELL; i++) begin
            acc = grad_m[i] + x[i] * g;
            if (acc > (longint'(1) << 47) - 1) begin
               acc = (longint'(1) << 47) - 1;
            end
            if (acc < -(longint'(1) << 47)) begin
               acc = -(longint'(1) << 47);
            end
            grad_m[i] = acc;
         end
      end
      return 16'(y);
   endfunction

   function automatic request_type make_req(logic [1:0] a, logic [CELLS_W-1:0] c,
                                            logic s, logic [1:0] t);
      request_type r;
      r.action = a;
      r.cells = c;
      r.side = s;
      r.target = t;
      return r;
   endfunction

   function automatic logic [CELLS_W-1:0] random_board();
      return CELLS_W'($urandom);
   endfunction

   function automatic void add_random(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 4) != 0) begin
            for (int j = $urandom_range(1, 12); j > 0; j--) begin
               pending_reqs.push_back(make_req(($urandom_range(0, 5) == 0) ? ACT_EVAL
                                                                          : ACT_TRAIN,
                  random_board(), 1'($urandom), 2'($urandom)));
               n++;
            end
            pending_reqs.push_back(make_req(ACT_UPDATE, random_board(),
                                            1'($urandom), 2'($urandom)));
            n++;
         end else begin
            pending_reqs.push_back(make_req(2'($urandom), random_board(),
                                            1'($urandom), 2'($urandom)));
            n++;
         end
      end
   endfunction

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || value_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_scale(logic [31:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      scale_m = v;
   endtask

   // Request driver: bursts of requests separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || took) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_valid <= 1'b1;
            req_action <= pending_reqs[0].action;
            req_cells <= pending_reqs[0].cells;
            req_side_to_move <= pending_reqs[0].side;
            req_expected <= pending_reqs[0].target;
            void'(pending_reqs.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall pattern.
   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_span <= $urandom_range(50, 300);
         stall_mode <= $urandom_range(0, 2);
      end else begin
         stall_span <= stall_span - 1;
      end
      if (stall_mode == 0) begin
         rsp_stall <= 1'b0;
      end else if (stall_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end else begin
         rsp_stall <= ($urandom_range(0, 9) != 0);
      end
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      request_type r;
      logic signed [15:0] want;
      took <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (value_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected response: value %0d", rsp_value);
               end
            end else begin
               want = value_queue.pop_front();
               if (rsp_value !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Value mismatch: expected %0d, actual %0d", want, rsp_value);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            r = make_req(req_action, req_cells, req_side_to_move, req_expected);
            value_queue.push_back(neuron_value(r));
         end
      end
   end

   initial begin
      logic [31:0] scales[5];
      build_nodes();
      scale_m = 32'd171799;
      for (int i = 0; i < NCELL; i++) begin
         weight_m[i] = 0;
         grad_m[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(make_req(ACT_EVAL, 18'h15555, 1'b0, 2'd0));
      pending_reqs.push_back(make_req(ACT_TRAIN, 18'h15555, 1'b0, 2'd1));
      pending_reqs.push_back(make_req(ACT_TRAIN, 18'h2aaaa, 1'b1, 2'd3));
      pending_reqs.push_back(make_req(ACT_TRAIN, 18'h3ffff, 1'b0, 2'd2));
      pending_reqs.push_back(make_req(ACT_TRAIN, 18'h00000, 1'b1, 2'd1));
      pending_reqs.push_back(make_req(ACT_UPDATE, 18'h3ffff, 1'b1, 2'd3));
      pending_reqs.push_back(make_req(ACT_SPARE, 18'h15555, 1'b0, 2'd1));
      pending_reqs.push_back(make_req(ACT_SPARE, 18'h2aaaa, 1'b1, 2'd2));
      pending_reqs.push_back(make_req(ACT_EVAL, 18'h26a59, 1'b0, 2'd0));
      wait_idle();

      scales[0] = 32'hffff_ffff;
      scales[1] = 32'd0;
      scales[2] = 32'd171799 * 64;
      scales[3] = $urandom;
      scales[4] = 32'd171799;
      for (int p = 0; p < 5; p++) begin
         write_scale(scales[p]);
         add_random(p == 0 ? 250 : 150);
         wait_idle();
      end

      if (value_queue.size() != 0) begin
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
